[design/psgd_pkg.sv]
// Shared constants and types for the push-switch gesture decoder.
package psgd_pkg;

    localparam int NUM_SWITCHES_DEF    = 9;
    localparam int HOLD_COUNT_BITS_DEF = 16;

    localparam int HOLD_TICKS_W = 16;
    localparam int CHORD_W      = 9;
    localparam int DIP_W        = 8;
    localparam int CODE_W       = 10;
    localparam int LEVEL_W      = 2;
    localparam int GESTURE_W    = 4;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [HOLD_TICKS_W-1:0] HOLD_TICKS_RESET = 16'd200;
    localparam logic [CHORD_W-1:0]      CHORD_MASK_RESET = 9'h028;

    // Single switches two through nine map onto consecutive gesture codes.
    localparam int SINGLE_FIRST = 2;
    localparam int SINGLE_LAST  = 9;

    localparam logic [CODE_W-1:0] CODE_VOL_DOWN = 10'd114;
    localparam logic [CODE_W-1:0] CODE_VOL_UP   = 10'd115;
    localparam logic [CODE_W-1:0] CODE_BACK     = 10'd158;

    localparam logic [LEVEL_W-1:0] LEVEL_RELEASE = 2'd0;

    localparam logic [GESTURE_W-1:0] G_UNDEF    = 4'd0;
    localparam logic [GESTURE_W-1:0] G_SHORT    = 4'd1;
    localparam logic [GESTURE_W-1:0] G_LONG     = 4'd2;
    localparam logic [GESTURE_W-1:0] G_KEY_BASE = 4'd3;
    localparam logic [GESTURE_W-1:0] G_CHORD    = 4'd11;
    localparam logic [GESTURE_W-1:0] G_VOL_DOWN = 4'd12;
    localparam logic [GESTURE_W-1:0] G_VOL_UP   = 4'd13;
    localparam logic [GESTURE_W-1:0] G_BACK     = 4'd14;
    localparam logic [GESTURE_W-1:0] G_RESET    = 4'd15;

    typedef enum logic [0:0] {
        REG_HOLD_TICKS = 1'b0,
        REG_CHORD_MASK = 1'b1
    } cfg_reg_t;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_KEY    = 3'd1,
        PH_DIP    = 3'd2,
        PH_CHORD  = 3'd3,
        PH_SINGLE = 3'd4,
        PH_HOLD   = 3'd5,
        PH_UNDEF  = 3'd6
    } phase_t;

endpackage

[design/psgd_poll_if.sv]
// Handshake channel carrying one poll sample word.
interface psgd_poll_if
    import psgd_pkg::*;
#(
    parameter int SW_BITS = NUM_SWITCHES_DEF
) ();
    logic                valid;
    logic                ready;
    logic [SW_BITS-1:0]  switch_bits;
    logic [DIP_W-1:0]    dip_level;
    logic                event_valid;
    logic [CODE_W-1:0]   event_code;
    logic [LEVEL_W-1:0]  event_level;

    modport source (
        output valid, switch_bits, dip_level, event_valid, event_code, event_level,
        input  ready
    );

    modport sink (
        input  valid, switch_bits, dip_level, event_valid, event_code, event_level,
        output ready
    );
endinterface

[design/psgd_report_if.sv]
// Handshake channel carrying one gesture report word.
interface psgd_report_if
    import psgd_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [GESTURE_W-1:0] gesture;

    modport source (
        output valid, gesture,
        input  ready
    );

    modport sink (
        input  valid, gesture,
        output ready
    );
endinterface

[design/push_switch_gesture_decoder_core.sv]
// Top level of the push-switch gesture decoder: input stage, decode logic, report register.
//
// The poll channel takes one word per sample: switch levels, DIP byte and an
// optional key event. The report channel returns a gesture word when a gesture
// completes, which is usually on release; most samples produce no word at all.
// Two registers, hold_ticks (byte address 0) and chord_mask (byte address 4),
// sit on the APB port; the user must write them only while the decoder is idle, as the block does not enforce it.
//
// A sample is registered on acceptance and decoded when it leaves the input
// register, where the gesture state is updated and any report is loaded into
// the output register. One sample is accepted per cycle while no report is
// stalled; the single decode stage between the input register and the report
// register sets that rate.
//
// If the receiver stalls with a report pending, the input stage takes at most
// one more sample and then holds ready low until the report is taken.
// Reset clears the gesture state, empties both stages and restores the
// register defaults (hold_ticks 200, chord_mask 0x28).
module push_switch_gesture_decoder_core
    import psgd_pkg::*;
#(
    parameter int NUM_SWITCHES    = NUM_SWITCHES_DEF,
    parameter int HOLD_COUNT_BITS = HOLD_COUNT_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    psgd_poll_if.sink             poll,
    psgd_report_if.source         report
);

    localparam logic [NUM_SWITCHES-1:0] SW_ONE =
        {1'b1, {(NUM_SWITCHES-1){1'b0}}};
    localparam logic [HOLD_COUNT_BITS-1:0] HOLD_MAX = '1;
    localparam int CMP_W = (HOLD_COUNT_BITS > HOLD_TICKS_W) ? HOLD_COUNT_BITS
                                                             : HOLD_TICKS_W;

    // Configuration registers
    logic [HOLD_TICKS_W-1:0] hold_ticks_reg;
    logic [CHORD_W-1:0]      chord_mask_reg;
    logic                    cfg_write;
    cfg_reg_t                cfg_sel;

    // Input stage
    logic                    s1_valid_reg;
    logic [NUM_SWITCHES-1:0] s1_bits_reg;
    logic [DIP_W-1:0]        s1_dip_reg;
    logic                    s1_ev_reg;
    logic [CODE_W-1:0]       s1_code_reg;
    logic [LEVEL_W-1:0]      s1_level_reg;
    logic                    advance;

    // Gesture state
    phase_t                     phase_reg,   phase_next;
    logic [NUM_SWITCHES-1:0]    held_mask_reg, held_mask_next;
    logic [GESTURE_W-1:0]       pending_reg, pending_next;
    logic [HOLD_COUNT_BITS-1:0] hold_count_reg, hold_count_next;

    // Report register
    logic                 out_valid_reg, out_valid_next;
    logic [GESTURE_W-1:0] out_gesture_reg;

    logic                    emit;
    logic [GESTURE_W-1:0]    emit_g;
    logic [NUM_SWITCHES-1:0] chord;
    logic                    chord_hit;
    logic                    single_hit;
    logic [GESTURE_W-1:0]    single_g;
    logic                    extra_press;
    logic                    long_hold;

    // ------------------------------------------------------------------
    // APB register file
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_sel   = cfg_reg_t'(paddr[2]);
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_ticks_reg <= HOLD_TICKS_RESET;
            chord_mask_reg <= CHORD_MASK_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_sel)
                REG_HOLD_TICKS: hold_ticks_reg <= pwdata[HOLD_TICKS_W-1:0];
                REG_CHORD_MASK: chord_mask_reg <= pwdata[CHORD_W-1:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_sel)
            REG_HOLD_TICKS: prdata = APB_DATA_W'(hold_ticks_reg);
            REG_CHORD_MASK: prdata = APB_DATA_W'(chord_mask_reg);
        endcase
    end

    // ------------------------------------------------------------------
    // Input stage
    // ------------------------------------------------------------------
    assign advance    = s1_valid_reg && (!out_valid_reg || report.ready);
    assign poll.ready = !s1_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (poll.ready)
            s1_valid_reg <= poll.valid;
    end

    always_ff @(posedge clk)
    begin
        if (poll.ready && poll.valid)
        begin
            s1_bits_reg  <= poll.switch_bits;
            s1_dip_reg   <= poll.dip_level;
            s1_ev_reg    <= poll.event_valid;
            s1_code_reg  <= poll.event_code;
            s1_level_reg <= poll.event_level;
        end
    end

    // ------------------------------------------------------------------
    // Decode
    // ------------------------------------------------------------------
    assign chord       = NUM_SWITCHES'(chord_mask_reg);
    assign chord_hit   = (chord != '0) && (s1_bits_reg == chord);
    assign extra_press = (s1_bits_reg | held_mask_reg) != held_mask_reg;
    assign long_hold   = CMP_W'(hold_count_reg) >= CMP_W'(hold_ticks_reg);

    // Switches two through nine alone; switches above nine are not matched.
    always_comb
    begin
        single_hit = 1'b0;
        single_g   = G_UNDEF;
        for (int k = SINGLE_FIRST; k <= SINGLE_LAST; k++)
        begin
            if (s1_bits_reg == (SW_ONE >> (k - 1)))
            begin
                single_hit = 1'b1;
                single_g   = G_KEY_BASE + GESTURE_W'(k - SINGLE_FIRST);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            held_mask_reg  <= '0;
            pending_reg    <= G_UNDEF;
            hold_count_reg <= '0;
        end
        else
        begin
            phase_reg      <= phase_next;
            held_mask_reg  <= held_mask_next;
            pending_reg    <= pending_next;
            hold_count_reg <= hold_count_next;
        end
    end

    always_comb
    begin
        phase_next      = phase_reg;
        held_mask_next  = held_mask_reg;
        pending_next    = pending_reg;
        hold_count_next = hold_count_reg;
        emit            = 1'b0;
        emit_g          = G_UNDEF;

        if (advance)
        begin
            unique case (phase_reg)
                PH_IDLE:
                begin
                    if (s1_ev_reg)
                    begin
                        // A known key code waits for its release; others report undefined.
                        if (s1_code_reg == CODE_VOL_DOWN)
                        begin
                            pending_next = G_VOL_DOWN;
                            phase_next   = PH_KEY;
                        end
                        else if (s1_code_reg == CODE_VOL_UP)
                        begin
                            pending_next = G_VOL_UP;
                            phase_next   = PH_KEY;
                        end
                        else if (s1_code_reg == CODE_BACK)
                        begin
                            pending_next = G_BACK;
                            phase_next   = PH_KEY;
                        end
                        else
                            emit = 1'b1;
                    end
                    else if (s1_dip_reg == '0)
                        phase_next = PH_DIP;
                    else if (s1_bits_reg != '0)
                    begin
                        if (chord_hit)
                        begin
                            phase_next     = PH_CHORD;
                            held_mask_next = s1_bits_reg;
                        end
                        else if (s1_bits_reg == SW_ONE)
                        begin
                            phase_next      = PH_HOLD;
                            held_mask_next  = s1_bits_reg;
                            hold_count_next = '0;
                        end
                        else if (single_hit)
                        begin
                            phase_next     = PH_SINGLE;
                            held_mask_next = s1_bits_reg;
                            pending_next   = single_g;
                        end
                        else
                            emit = 1'b1;
                    end
                end
                PH_KEY:
                begin
                    if (s1_ev_reg && (s1_level_reg == LEVEL_RELEASE))
                    begin
                        emit       = 1'b1;
                        emit_g     = pending_reg;
                        phase_next = PH_IDLE;
                    end
                end
                PH_DIP:
                begin
                    if (s1_dip_reg != '0)
                    begin
                        emit       = 1'b1;
                        emit_g     = G_RESET;
                        phase_next = PH_IDLE;
                    end
                end
                PH_SINGLE:
                begin
                    if (chord_hit)
                    begin
                        phase_next     = PH_CHORD;
                        held_mask_next = chord;
                    end
                    else if (extra_press)
                        phase_next = PH_UNDEF;
                    else if (s1_bits_reg == '0)
                    begin
                        emit       = 1'b1;
                        emit_g     = pending_reg;
                        phase_next = PH_IDLE;
                    end
                end
                PH_CHORD:
                begin
                    if (extra_press)
                        phase_next = PH_UNDEF;
                    else if (s1_bits_reg == '0)
                    begin
                        emit       = 1'b1;
                        emit_g     = G_CHORD;
                        phase_next = PH_IDLE;
                    end
                end
                PH_HOLD:
                begin
                    if (extra_press)
                        phase_next = PH_UNDEF;
                    else if (s1_bits_reg == '0)
                    begin
                        emit       = 1'b1;
                        emit_g     = long_hold ? G_LONG : G_SHORT;
                        phase_next = PH_IDLE;
                    end
                    else if (hold_count_reg != HOLD_MAX)
                        hold_count_next = hold_count_reg + 1'b1;
                end
                PH_UNDEF:
                begin
                    if (s1_bits_reg == '0)
                    begin
                        emit       = 1'b1;
                        phase_next = PH_IDLE;
                    end
                end
                default:
                    phase_next = PH_IDLE;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Report register
    // ------------------------------------------------------------------
    assign out_valid_next = advance ? emit : (out_valid_reg && !report.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit)
            out_gesture_reg <= emit_g;
    end

    assign report.valid   = out_valid_reg;
    assign report.gesture = out_gesture_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_hold_mask: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_HOLD) |-> (held_mask_reg == SW_ONE))
        else $error("hold gesture tracks a mask other than switch one");

    a_key_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_KEY) |-> ((pending_reg == G_VOL_DOWN) ||
                                   (pending_reg == G_VOL_UP) ||
                                   (pending_reg == G_BACK)))
        else $error("key wait holds a gesture that is not a key code");

    a_chord_mask: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_CHORD) |-> (held_mask_reg != '0))
        else $error("chord gesture with an empty held mask");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !poll.ready |-> (s1_valid_reg && out_valid_reg && !report.ready))
        else $error("poll channel stalled without a pending report");

    a_no_emit_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !report.ready) |=> $stable(phase_reg))
        else $error("gesture state moved while the report was stalled");

endmodule
